FILE: rtl/mmw_pkg.sv
//------------------------------------------------------------------------------
// mmw_pkg
// Shared types and constants for the multi-mode waveshaper.
//------------------------------------------------------------------------------
package mmw_pkg;

    localparam int unsigned DEF_SAMPLE_WIDTH  = 24;
    localparam int unsigned DEF_FRACTION_BITS = 20;
    localparam int unsigned GAIN_WIDTH        = 16;
    localparam int unsigned GAIN_FRAC         = 12;
    localparam int unsigned CORDIC_STEPS      = 24;
    localparam logic [31:0] TWO_OVER_PI_Q30   = 32'd683565276;
    localparam logic [15:0] GAIN_RESET        = 16'd4096;

    typedef enum logic [1:0] {
        MODE_SOFT  = 2'd0,
        MODE_CUBIC = 2'd1,
        MODE_TANH  = 2'd2,
        MODE_ATAN  = 2'd3
    } t_mode;

    typedef enum logic [0:0] {
        REG_MODE = 1'b0,
        REG_GAIN = 1'b1
    } t_reg_addr;

    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] v;
        unique case (idx)
            0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
            3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
            6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
            9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
            18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
            21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/mmw_stream_if.sv
//------------------------------------------------------------------------------
// mmw_stream_if
// Valid/ready stream carrying one payload word.
//------------------------------------------------------------------------------
interface mmw_stream_if #(
    parameter int unsigned WIDTH = 24
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/mmw_core.sv
//------------------------------------------------------------------------------
// mmw_core
// Stall-able pipeline that shapes, scales and saturates one sample a cycle.
//------------------------------------------------------------------------------
module mmw_core #(
    parameter int unsigned SAMPLE_WIDTH  = 24,
    parameter int unsigned FRACTION_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample,
    input  logic [1:0]                        i_mode,
    input  logic [15:0]                       i_gain,
    output logic                              o_valid,
    output logic [SAMPLE_WIDTH-1:0]           o_sample,
    output logic                              o_sat
);
    import mmw_pkg::*;

    // Stage plan (all advance together on i_en):
    //  S0        : magnitude, mode-specific prescale
    //  C0..C23   : CORDIC iterations (one per stage)
    //  T-stages  : tanh polynomial then serial divider, run alongside
    //  D stages  : soft-rational restoring divider, alongside
    //  F stages  : curve select, 2/pi scaling, cubic divide by three, gain
    //              multiply, saturation
    // Each curve is evaluated in parallel; a deep common pipeline keeps
    // every path the same length.
    localparam int unsigned W   = SAMPLE_WIDTH;
    localparam int unsigned FB  = FRACTION_BITS;
    localparam int unsigned MW  = W;            // magnitude width (holds 2^(W-1))
    // Soft quotient < one, so FB bits; tanh ratio <= 2^18 so 19 bits.
    localparam int unsigned SQ  = FB;
    localparam int unsigned TQ  = 19;
    localparam int unsigned NST = 32;           // shaping pipeline depth

    // ---- Stage 0: magnitude --------------------------------------------------
    logic [MW-1:0] w_mag;
    logic          w_neg;
    assign w_neg = i_sample[W-1];
    assign w_mag = w_neg ? (MW'(0) - i_sample) : i_sample;

    // Per-item context through the pipe.
    logic [NST:0]        r_v;
    logic [NST:0]        r_ng;
    logic [1:0]          r_md   [NST+1];
    logic [15:0]         r_gn   [NST+1];
    logic [MW-1:0]       r_m    [NST+1];

    // CORDIC state (Q.30 with headroom: y up to 2^(W-1+30-FB)).
    localparam int unsigned CW = W + 32 - FB + 2;
    logic signed [CW-1:0] r_cx [NST+1];
    logic signed [CW-1:0] r_cy [NST+1];
    logic signed [33:0]   r_cz [NST+1];

    // Soft divider: numerator m<<FB, denominator m+one. The remainder starts
    // at m, which is below the denominator, and zeros are shifted in.
    localparam int unsigned DW = MW + 2;
    logic [DW-1:0] r_sr  [NST+1];
    logic [DW-1:0] r_sd  [NST+1];
    logic [SQ-1:0] r_sq  [NST+1];

    // Tanh path: u (Q.24, <=5*2^24 < 2^27), polynomial regs, divider.
    logic [26:0]  r_u    [NST+1];
    logic [49:0]  r_x2   [NST+1];
    logic [49:0]  r_x4   [NST+1];
    logic [49:0]  r_x6   [NST+1];
    logic [63:0]  r_tp   [NST+1];
    logic [63:0]  r_td   [NST+1];
    logic [63:0]  r_tr   [NST+1];
    logic [TQ-1:0] r_tq  [NST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NST-1:0], i_valid};
        end
    end

    // Stage-0 load.
    logic [26:0] w_u0;
    always_comb begin
        logic [MW-1:0] lim;
        lim = MW'(5) << FB;
        if (FB <= 24) begin
            w_u0 = 27'((w_mag > lim ? lim : w_mag)) << (24 - FB);
        end else begin
            w_u0 = 27'((w_mag > lim ? lim : w_mag) >> (FB - 24));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ng[0] <= w_neg;
            r_md[0] <= i_mode;
            r_gn[0] <= i_gain;
            r_m[0]  <= w_mag;
            r_cx[0] <= CW'(64'sd1 <<< 30);
            r_cy[0] <= CW'(w_mag) <<< (30 - FB);
            r_cz[0] <= '0;
            r_sr[0] <= DW'(w_mag);
            r_sd[0] <= DW'(w_mag) + (DW'(1) << FB);
            r_sq[0] <= '0;
            r_u[0]  <= w_u0;
            r_x2[0] <= '0; r_x4[0] <= '0; r_x6[0] <= '0;
            r_tp[0] <= '0; r_td[0] <= '0; r_tr[0] <= '0; r_tq[0] <= '0;
        end
    end

    // ---- Shaping stages ------------------------------------------------------
    for (genvar s = 0; s < NST; s++) begin : g_st
        always_ff @(posedge i_clk) begin
            logic signed [CW-1:0] sx, sy, nx, ny;
            logic signed [33:0]   nz;
            logic [DW-1:0]        rem;
            logic [63:0]          trem;
            if (i_en) begin
                r_ng[s+1] <= r_ng[s];
                r_md[s+1] <= r_md[s];
                r_gn[s+1] <= r_gn[s];
                r_m[s+1]  <= r_m[s];
                r_u[s+1]  <= r_u[s];
                r_sd[s+1] <= r_sd[s];
                // CORDIC iteration s
                if (s < CORDIC_STEPS) begin
                    sx = r_cx[s] >>> s;
                    sy = r_cy[s] >>> s;
                    if (r_cy[s] > 0) begin
                        nx = r_cx[s] + sy; ny = r_cy[s] - sx;
                        nz = r_cz[s] + 34'(atan_q30(s));
                    end else begin
                        nx = r_cx[s] - sy; ny = r_cy[s] + sx;
                        nz = r_cz[s] - 34'(atan_q30(s));
                    end
                    r_cx[s+1] <= nx; r_cy[s+1] <= ny; r_cz[s+1] <= nz;
                end else begin
                    r_cx[s+1] <= r_cx[s]; r_cy[s+1] <= r_cy[s];
                    r_cz[s+1] <= r_cz[s];
                end
                // Soft divider: one quotient bit per stage, MSB first.
                if (s < SQ) begin
                    rem = {r_sr[s][DW-2:0], 1'b0};
                    if (rem >= r_sd[s]) begin
                        r_sr[s+1] <= rem - r_sd[s];
                        r_sq[s+1] <= {r_sq[s][SQ-2:0], 1'b1};
                    end else begin
                        r_sr[s+1] <= rem;
                        r_sq[s+1] <= {r_sq[s][SQ-2:0], 1'b0};
                    end
                end else begin
                    r_sr[s+1] <= r_sr[s];
                    r_sq[s+1] <= r_sq[s];
                end
                // Tanh: stages 0..3 form the polynomial, then 19 divide steps.
                if (s == 0) begin
                    r_x2[s+1] <= 50'((54'(r_u[s]) * 54'(r_u[s])) >> 24);
                end else begin
                    r_x2[s+1] <= r_x2[s];
                end
                if (s == 1) begin
                    r_x4[s+1] <= 50'((64'(r_x2[s][28:0]) * 64'(r_x2[s][28:0])) >> 24);
                end else begin
                    r_x4[s+1] <= r_x4[s];
                end
                if (s == 2) begin
                    r_x6[s+1] <= 50'((64'(r_x4[s][33:0]) * 64'(r_x2[s][28:0])) >> 24);
                end else begin
                    r_x6[s+1] <= r_x6[s];
                end
                if (s == 3) begin
                    r_tp[s+1] <= (64'd135135 << 24) + 64'd17325 * 64'(r_x2[s])
                               + 64'd378 * 64'(r_x4[s]) + 64'(r_x6[s]);
                    r_td[s+1] <= (64'd135135 << 24) + 64'd62370 * 64'(r_x2[s])
                               + 64'd3150 * 64'(r_x4[s]) + 64'd28 * 64'(r_x6[s]);
                end else begin
                    r_tp[s+1] <= r_tp[s];
                    r_td[s+1] <= r_td[s];
                end
                if (s >= 4 && s < 4 + TQ) begin
                    // The numerator never exceeds the denominator, so the first
                    // step compares p itself and later steps shift in zeros.
                    trem = (s == 4) ? r_tp[s] : {r_tr[s][62:0], 1'b0};
                    if (trem >= r_td[s]) begin
                        r_tr[s+1] <= trem - r_td[s];
                        r_tq[s+1] <= {r_tq[s][TQ-2:0], 1'b1};
                    end else begin
                        r_tr[s+1] <= trem;
                        r_tq[s+1] <= {r_tq[s][TQ-2:0], 1'b0};
                    end
                end else begin
                    r_tr[s+1] <= r_tr[s];
                    r_tq[s+1] <= r_tq[s];
                end
            end
        end
    end

    // ---- Final stages: select, scale, gain, saturate ------------------------
    // F1: curve select and tanh product; F2: 2/pi multiply; F3: cubic divide
    // by three; F4: gain; F5: sat.
    logic [MW-1:0] w_cubic_pre;
    logic [63:0]   w_tt;

    logic          r_f1v, r_f2v, r_f3v, r_f4v, r_f5v;
    logic          r_f1n, r_f2n, r_f3n, r_f4n;
    logic [1:0]    r_f1md;
    logic [15:0]   r_f1g, r_f2g, r_f3g;
    logic [MW-1:0] r_f1m;
    logic [31:0]   r_f1a;   // value needing 2/pi (Q.FB, Q.30 for atan), or direct shaped
    logic [MW-1:0] r_f2s;
    logic          r_cmode;
    logic [MW-1:0] r_f3s;
    logic [MW+16:0] r_f4p;
    logic [W-1:0]  r_osamp;
    logic          r_osat;
    logic [31:0]   r_c2, r_c3;

    always_comb begin
        logic [63:0] t;
        t = (64'(r_u[NST]) * 64'(r_tq[NST])) >> 18;
        if (t > (64'd1 << 24)) t = 64'd1 << 24;
        w_tt = (FB <= 24) ? (t >> (24 - FB)) : (t << (FB - 24));
    end
    assign w_cubic_pre = r_m[NST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1v <= 1'b0; r_f2v <= 1'b0; r_f3v <= 1'b0; r_f4v <= 1'b0;
            r_f5v <= 1'b0;
        end else if (i_en) begin
            r_f1v <= r_v[NST]; r_f2v <= r_f1v; r_f3v <= r_f2v; r_f4v <= r_f3v;
            r_f5v <= r_f4v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [63:0] a, sc, c3d;
        logic [MW-1:0] shp;
        logic [MW+16:0] lim;
        if (i_en) begin
            // F1
            r_f1n  <= r_ng[NST]; r_f1md <= r_md[NST]; r_f1g <= r_gn[NST];
            r_f1m  <= w_cubic_pre;
            r_f1a  <= (r_md[NST] == MODE_SOFT) ? 32'(r_sq[NST]) :
                      (r_md[NST] == MODE_TANH) ? 32'(w_tt) :
                      (r_cz[NST] < 0 ? 32'd0 : 32'(r_cz[NST]));
            r_c2   <= 32'((64'(w_cubic_pre) * 64'(w_cubic_pre)) >> FB);
            // F2
            r_f2n <= r_f1n; r_f2g <= r_f1g;
            r_c3  <= 32'((64'(r_c2) * 64'(r_f1m)) >> FB);
            sc    = (64'(r_f1a) * 64'(TWO_OVER_PI_Q30)) >> 30;
            unique case (t_mode'(r_f1md))
                MODE_SOFT:  shp = MW'(r_f1a);
                MODE_CUBIC: shp = '0;
                MODE_TANH:  shp = MW'(sc);
                default: begin
                    a = sc;
                    if (a > (64'd1 << 30)) a = 64'd1 << 30;
                    shp = (FB <= 30) ? MW'(a >> (30 - FB)) : MW'(a << (FB - 30));
                end
            endcase
            r_f2s <= (t_mode'(r_f1md) == MODE_CUBIC) ?
                     ((r_f1m > (MW'(1) << FB)) ? MW'((64'd2 << FB) / 3)
                                               : r_f1m) : shp;
            r_cmode <= (t_mode'(r_f1md) == MODE_CUBIC) && !(r_f1m > (MW'(1) << FB));
            // F3: x^3/3 by multiplying with the reciprocal of three, exact for
            // any 32-bit dividend.
            r_f3n <= r_f2n; r_f3g <= r_f2g;
            c3d   = (64'(r_c3) * 64'h0000_0000_AAAA_AAAB) >> 33;
            r_f3s <= r_cmode ? (r_f2s - MW'(c3d)) : r_f2s;
            // F4
            r_f4n <= r_f3n;
            r_f4p <= (MW+17)'((64'(r_f3s) * 64'(r_f3g)) >> GAIN_FRAC);
            // F5
            lim = r_f4n ? ((MW+17)'(1) << (W-1)) : (((MW+17)'(1) << (W-1)) - 1'b1);
            if (r_f4p > lim) begin
                r_osat  <= 1'b1;
                r_osamp <= r_f4n ? W'(MW'(0) - MW'(lim)) : W'(lim);
            end else begin
                r_osat  <= 1'b0;
                r_osamp <= r_f4n ? W'(MW'(0) - MW'(r_f4p)) : W'(r_f4p);
            end
        end
    end

    assign o_valid  = r_f5v;
    assign o_sample = r_osamp;
    assign o_sat    = r_osat;

endmodule

FILE: rtl/multi_mode_waveshaper.sv
//------------------------------------------------------------------------------
// multi_mode_waveshaper
// Soft clipper with four selectable curves, output gain and saturation.
//------------------------------------------------------------------------------
// Takes one signed sample word per cycle and returns one shaped word per
// sample, through one input stage, 32 shaping stages and five finishing
// stages. The shaping stages hold the 24-step arctangent CORDIC and the
// bit-serial dividers, one stage per step; every curve is computed
// in parallel and the configured curve is selected near the end. A stall
// on the output freezes the whole pipeline, with no word lost or repeated.
// curve_mode and output_gain are written through the APB port; the user
// must write them only while the block is idle, which it does not enforce.
module multi_mode_waveshaper #(
    parameter int unsigned SAMPLE_WIDTH  = mmw_pkg::DEF_SAMPLE_WIDTH,
    parameter int unsigned FRACTION_BITS = mmw_pkg::DEF_FRACTION_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    mmw_stream_if.sink   in_if,
    mmw_stream_if.source out_if
);
    import mmw_pkg::*;

    logic [1:0]  r_mode;
    logic [15:0] r_gain;
    logic        w_en;
    logic        w_valid, w_sat;
    logic [SAMPLE_WIDTH-1:0] w_sample;

    assign pready = 1'b1;

    // Register writes complete in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 2'(MODE_SOFT);
            r_gain <= GAIN_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            if (t_reg_addr'(paddr[2]) == REG_MODE) begin
                r_mode <= pwdata[1:0];
            end else begin
                r_gain <= pwdata[15:0];
            end
        end
    end

    always_comb begin
        if (t_reg_addr'(paddr[2]) == REG_MODE) begin
            prdata = {30'd0, r_mode};
        end else begin
            prdata = {16'd0, r_gain};
        end
    end

    // The pipeline advances whenever its last stage is empty or drained.
    assign w_en        = !out_if.valid || out_if.ready;
    assign in_if.ready = w_en;

    mmw_core #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (in_if.valid),
        .i_sample (in_if.data[SAMPLE_WIDTH-1:0]),
        .i_mode   (r_mode),
        .i_gain   (r_gain),
        .o_valid  (w_valid),
        .o_sample (w_sample),
        .o_sat    (w_sat)
    );

    assign out_if.valid = w_valid;
    assign out_if.data  = {w_sat, w_sample};

endmodule
